[hdl/partition_fit_allocator_core_defines.svh]
// ---------------------------------------------------------------------------
// Partition fit allocator: assertion macros
// Shared concurrent assertion helpers. The enclosing scope provides clk and
// rst_n.
// ---------------------------------------------------------------------------
`ifndef PARTITION_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define PARTITION_FIT_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PFA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfa: implication check failed");

// next-cycle implication, checked outside reset
`define PFA_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfa: next-cycle check failed");

`endif

[hdl/pfa_pkg.sv]
// ---------------------------------------------------------------------------
// Partition fit allocator package
// Request/result types, register indexes, codes and controller types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

  // field widths
  localparam int SIZE_W     = 16;
  localparam int PIDX_W     = 3;
  localparam int COUNT_W    = 4;
  localparam int STRAT_W    = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PLACE = 1'b1;

  // placement strategies (unused code behaves as first fit)
  localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
  localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
  localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 1'd1;

  // register reset values
  localparam logic [STRAT_W-1:0] STRATEGY_RESET = STRAT_FIRST;
  localparam logic [COUNT_W-1:0] COUNT_RESET    = 4'd8;

  typedef struct packed {
    logic              cmd;
    logic [PIDX_W-1:0] partition_index;
    logic [SIZE_W-1:0] size_value;
  } pfa_in_t;

  typedef struct packed {
    logic              placed;
    logic [PIDX_W-1:0] block_index;
    logic [SIZE_W-1:0] remaining_free;
  } pfa_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_WB,
    ST_OUT
  } pfa_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;    // capture request, clear scan
    logic do_load;   // write loaded size, form load result
    logic scan_en;   // step the table scan
    logic do_wb;     // write back chosen entry, form placement result
    logic out_load;  // move result into output register
  } pfa_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } pfa_sts_t;

endpackage

`default_nettype wire

[hdl/pfa_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/pfa_ctrl.sv]
// ---------------------------------------------------------------------------
// Partition fit allocator controller
// Sequences load, scan, write-back and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfa_ctrl
  import pfa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_cmd,
  output logic          in_stall,
  output pfa_ctl_t      ctl,
  input  wire pfa_sts_t sts
);

  pfa_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_nxt  = (in_cmd == CMD_PLACE) ? ST_SCAN : ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctl.do_load = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_SCAN: begin
        ctl.scan_en = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        ctl.do_wb = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/pfa_dpath.sv]
// ---------------------------------------------------------------------------
// Partition fit allocator datapath
// Free-size table, scan compare, write-back and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "partition_fit_allocator_core_defines.svh"

module pfa_dpath
  import pfa_pkg::*;
#(
  parameter int PARTITIONS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pfa_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output pfa_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire pfa_ctl_t              ctl,
  output pfa_sts_t                   sts
);

  localparam int AW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

  // configuration
  logic [STRAT_W-1:0] strategy_r;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] limit;

  // held request
  pfa_in_t item_r;
  logic    pidx_ok;

  // scan state
  logic [COUNT_W-1:0] rd_cnt_r;
  logic [COUNT_W-1:0] cmp_idx_r;
  logic               cmp_pend_r;
  logic               rd_issue;
  logic               found_r;
  logic [COUNT_W-1:0] best_idx_r;
  logic [SIZE_W-1:0]  best_val_r;
  logic [SIZE_W-1:0]  entry_val;
  logic               take;
  logic [SIZE_W-1:0]  new_val;

  // table
  logic [PARTITIONS-1:0] vld_r;
  logic                  vld_q_r;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [SIZE_W-1:0]     ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [SIZE_W-1:0]     ram_rdata;

  // result and output registers
  pfa_out_t res_r;
  pfa_out_t out_data_r;
  logic     out_valid_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strategy_r <= STRATEGY_RESET;
      count_r    <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STRATEGY: strategy_r <= cfg_wdata[STRAT_W-1:0];
        CFG_COUNT:    count_r    <= cfg_wdata[COUNT_W-1:0];
        default:      ;
      endcase
    end
  end

  // partitions in use, capped at the table size
  assign limit = (int'(count_r) > PARTITIONS) ? COUNT_W'(PARTITIONS) : count_r;

  // request capture
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      item_r <= in_data;
    end
  end

  assign pidx_ok = int'(item_r.partition_index) < PARTITIONS;

  // scan read issue, one entry a cycle
  assign rd_issue  = ctl.scan_en && (rd_cnt_r < limit);
  assign ram_raddr = AW'(rd_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r   <= '0;
      cmp_pend_r <= 1'b0;
    end else if (ctl.accept) begin
      rd_cnt_r   <= '0;
      cmp_pend_r <= 1'b0;
    end else begin
      cmp_pend_r <= rd_issue;
      if (rd_issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      cmp_idx_r <= rd_cnt_r;
      vld_q_r   <= vld_r[ram_raddr];
    end
  end

  assign sts.scan_done = (rd_cnt_r >= limit) && !cmp_pend_r;

  // fit compare; strict compares keep the lower index on ties
  assign entry_val = vld_q_r ? ram_rdata : '0;

  always_comb begin
    take = 1'b0;
    if (cmp_pend_r && (entry_val >= item_r.size_value)) begin
      if (!found_r) begin
        take = 1'b1;
      end else if (strategy_r == STRAT_BEST) begin
        take = entry_val < best_val_r;
      end else if (strategy_r == STRAT_WORST) begin
        take = entry_val > best_val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.accept) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r <= cmp_idx_r;
      best_val_r <= entry_val;
    end
  end

  assign new_val = best_val_r - item_r.size_value;

  // table write: load or write-back
  assign ram_we    = (ctl.do_load && pidx_ok) || (ctl.do_wb && found_r);
  assign ram_waddr = ctl.do_load ? AW'(item_r.partition_index) : AW'(best_idx_r);
  assign ram_wdata = ctl.do_load ? item_r.size_value : new_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_we) begin
      vld_r[ram_waddr] <= 1'b1;
    end
  end

  pfa_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (PARTITIONS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_issue),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result forming
  always_ff @(posedge clk) begin
    if (ctl.do_load) begin
      res_r.placed         <= 1'b0;
      res_r.block_index    <= item_r.partition_index;
      res_r.remaining_free <= pidx_ok ? item_r.size_value : '0;
    end else if (ctl.do_wb) begin
      res_r.placed         <= found_r;
      res_r.block_index    <= found_r ? best_idx_r[PIDX_W-1:0] : '0;
      res_r.remaining_free <= found_r ? new_val : '0;
    end
  end

  // output register
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `PFA_ASSERT_IMP(a_chosen_fits, found_r, best_val_r >= item_r.size_value)
  `PFA_ASSERT_IMP(a_scan_in_range, ctl.scan_en, rd_cnt_r <= limit)
  `PFA_ASSERT_IMP(a_pick_in_range, ctl.scan_en && found_r, best_idx_r < limit)
  `PFA_ASSERT_NXT(a_cmp_follows_read, rd_issue, cmp_pend_r)

endmodule

`default_nettype wire

[hdl/partition_fit_allocator_core.sv]
// ---------------------------------------------------------------------------
// Partition fit allocator
// First, best and worst fit placement over a table of partition free sizes.
//
//   channel  ports                          dir  request/write taken when
//   in       in_valid in_stall in_data      in   in_valid && !in_stall
//   out      out_valid out_stall out_data   out  out_valid && !out_stall
//   cfg      cfg_we cfg_index cfg_wdata     in   cfg_we
//
// A load passes through the load and output states; a placement scans
// min(partition_count, PARTITIONS) entries, reading one entry a cycle
// from the free-size RAM, then drains the last compare before write-back.
// One request is in work at a time; the next is taken while a finished
// result still waits in the output register.
// Reset (rst_n low, synchronous) clears the table to zero via per-entry
// valid bits, with no clearing pass; out_stall holds a result in place.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module partition_fit_allocator_core
  import pfa_pkg::*;
#(
  parameter int PARTITIONS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire pfa_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output pfa_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  pfa_ctl_t ctl;
  pfa_sts_t sts;

  // sequencing
  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_stall (in_stall),
    .ctl      (ctl),
    .sts      (sts)
  );

  // table and arithmetic
  pfa_dpath #(
    .PARTITIONS (PARTITIONS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

`default_nettype wire
